// File: rtl/core/septic_polynomial_trajectory_gen_core_assert.svh
// Assertion macros shared by the trajectory generator RTL.
`ifndef SEPTIC_POLYNOMIAL_TRAJECTORY_GEN_CORE_ASSERT_SVH
`define SEPTIC_POLYNOMIAL_TRAJECTORY_GEN_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define SPT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define SPT_ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SPT_ASSERT(name, prop, msg)
`define SPT_ASSERT_NEVER(name, expr, msg)
`endif
`endif

// File: rtl/core/spt_pkg.sv
// Types, constants and helper functions of the trajectory generator.
`default_nettype none

package spt_pkg;

    localparam int STEP_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int WIDE_W        = 64;
    localparam int POS_W         = 25;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int TAU_W         = 31;
    localparam int ACC_W         = 40;
    localparam int EXP_W         = 3;
    localparam int ITER_CNT_W    = 6;
    localparam int DIV_ITERS     = 64;
    localparam int SQRT_ITERS    = 32;
    localparam int Q30_SHIFT     = 30;
    localparam int POS_SHIFT     = 6;
    localparam int POS_ROUND     = 32;

    localparam logic [DATA_W-1:0] VEL_PEAK_RESET = 32'd143360;
    localparam logic [DATA_W-1:0] ACC_PEAK_RESET = 32'd492385;
    localparam logic [TAU_W-1:0]  ONE30          = 31'h4000_0000;
    localparam logic [POS_W-1:0]  POS_ONE        = 25'h100_0000;
    localparam logic [DATA_W-1:0] DERIV_GAIN     = 32'd140;

    // Exponents of the power chain
    localparam logic [EXP_W-1:0] EXP_P3        = 3'd3;
    localparam logic [EXP_W-1:0] EXP_FIRST_TERM = 3'd4;
    localparam logic [EXP_W-1:0] EXP_LAST      = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATH_LENGTH = 3'd0,
        REG_VEL_LIMIT   = 3'd1,
        REG_ACC_LIMIT   = 3'd2,
        REG_TIME_STEP   = 3'd3,
        REG_VEL_PEAK    = 3'd4,
        REG_ACC_PEAK    = 3'd5
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN  = 2'd0,
        ST_LAST = 2'd1,
        ST_IDLE = 2'd2,
        ST_ERR  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_NV_DEN,
        S_NV_START,
        S_NV_WAIT,
        S_X_START,
        S_X_WAIT,
        S_TA_WAIT,
        S_NA_WAIT,
        S_S0,
        S_S1,
        S_S2,
        S_S3,
        S_P_MUL,
        S_P_CAP,
        S_P_CMUL,
        S_P_ACC,
        S_U_MUL1,
        S_U_CAP1,
        S_U_MUL2,
        S_U_CAP2,
        S_U_MUL3,
        S_U_CAP3,
        S_U_MUL4,
        S_V_START,
        S_V_WAIT,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } div_cmd_t;

    // Saturate a wide value to 32 bits
    function automatic logic [DATA_W-1:0] sat32(input logic [WIDE_W-1:0] v);
        return (|v[WIDE_W-1:DATA_W]) ? {DATA_W{1'b1}} : v[DATA_W-1:0];
    endfunction

    // Q30 product with round to nearest
    function automatic logic [TAU_W-1:0] q30_round(input logic [WIDE_W-1:0] p);
        logic [WIDE_W-1:0] s;
        s = p + (WIDE_W'(1) << (Q30_SHIFT - 1));
        return s[Q30_SHIFT+TAU_W-1:Q30_SHIFT];
    endfunction

    // Magnitude of the polynomial coefficient of tau^e
    function automatic logic [7:0] poly_coef(input logic [EXP_W-1:0] e);
        logic [7:0] c;
        case (e)
            3'd4:    c = 8'd35;
            3'd5:    c = 8'd84;
            3'd6:    c = 8'd70;
            3'd7:    c = 8'd20;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/spt_cfg_if.sv
// Configuration write channel.
`default_nettype none

interface spt_cfg_if import spt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/spt_tick_if.sv
// Tick input channel.
`default_nettype none

interface spt_tick_if ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

// File: rtl/core/spt_result_if.sv
// Sample result channel.
`default_nettype none

interface spt_result_if import spt_pkg::*; #(parameter int STEP_BITS = STEP_BITS_DEF) ();
    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    sample_time;
    logic [POS_W-1:0]     position_fraction;
    logic [DATA_W-1:0]    velocity;
    logic [STEP_BITS-1:0] sample_number;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, output sample_time, output position_fraction,
                    output velocity, output sample_number, output status, input ready);
    modport sink (input valid, input sample_time, input position_fraction,
                  input velocity, input sample_number, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/septic_polynomial_trajectory_gen_core.sv
// Top level of the septic point-to-point trajectory generator.
//
// Channels: cfg writes the six Q16.16 registers by index (always ready);
// tick carries one restart bit per servo tick; result returns one sample
// (time, position in Q1.24, velocity, sample number, status) per tick.
// A restart tick checks the registers, sizes the profile as a whole number
// of time steps and returns sample zero; a plain tick returns the next one.
// The next tick can transfer in the same cycle as the previous tick's sample
// becomes valid. The time per tick is set by the shared one-bit-per-cycle
// divider plus the shared multiplier's power chain.
// A plain tick that only reports an error or a finished profile goes from
// idle straight to the output state; a restart that finds a zero register
// passes through the check state first.
// One tick is in work at a time; tick.ready is high while the sequencer is
// idle, even when a finished sample still waits in the output register.
// When the receiver stalls, that sample is held and the next one waits in
// the staging registers, with tick.ready low, until the output register frees up.
// Reset clears the profile state and loads the register reset values.
`default_nettype none
`include "septic_polynomial_trajectory_gen_core_assert.svh"

module septic_polynomial_trajectory_gen_core import spt_pkg::*; #(
    parameter int STEP_BITS = STEP_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    spt_cfg_if.sink        cfg,
    spt_tick_if.sink       tick,
    spt_result_if.source   result
);

    localparam logic [WIDE_W-1:0] XMAX = {WIDE_W{1'b1}} >> FRAC_BITS;
    localparam logic [WIDE_W-1:0] STEP_MAX = (WIDE_W'(1) << STEP_BITS) - WIDE_W'(1);
    localparam int VEL_SHIFT = Q30_SHIFT - FRAC_BITS;

    // Configuration registers
    logic [DATA_W-1:0] path_len_reg;
    logic [DATA_W-1:0] vel_lim_reg;
    logic [DATA_W-1:0] acc_lim_reg;
    logic [DATA_W-1:0] tstep_reg;
    logic [DATA_W-1:0] vpk_reg;
    logic [DATA_W-1:0] apk_reg;

    // Profile state
    seq_state_t           state_reg;
    seq_state_t           state_next;
    logic [STEP_BITS-1:0] counter_reg;
    logic [STEP_BITS-1:0] nsteps_reg;
    logic [DATA_W-1:0]    end_time_reg;
    logic                 running_reg;
    logic                 bad_reg;
    logic                 out_valid_reg;

    // Working registers
    logic                 restart_reg;
    logic [WIDE_W-1:0]    work_num_reg;
    logic [WIDE_W-1:0]    nv_reg;
    logic [WIDE_W-1:0]    den_reg;
    logic [TAU_W-1:0]     tau_reg;
    logic [TAU_W-1:0]     u_reg;
    logic [TAU_W-1:0]     p_reg;
    logic [TAU_W-1:0]     p3_reg;
    logic [TAU_W-1:0]     w_reg;
    logic [EXP_W-1:0]     exp_reg;
    logic [ACC_W-1:0]     plus_reg;
    logic [ACC_W-1:0]     minus_reg;

    // Staged sample
    logic [STEP_BITS-1:0] k_reg;
    logic [STATUS_W-1:0]  st_reg;
    logic [DATA_W-1:0]    time_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [DATA_W-1:0]    vel_reg;

    // Output register
    logic [DATA_W-1:0]    out_time_reg;
    logic [POS_W-1:0]     out_pos_reg;
    logic [DATA_W-1:0]    out_vel_reg;
    logic [STEP_BITS-1:0] out_num_reg;
    logic [STATUS_W-1:0]  out_status_reg;

    // Shared units
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [WIDE_W-1:0] prod;
    div_cmd_t          div_cmd;
    logic [WIDE_W-1:0] div_num;
    logic [WIDE_W-1:0] div_den;
    logic              div_done;
    logic [WIDE_W-1:0] div_quo;
    logic              div_rnz;

    // Helpers
    logic              tick_fire;
    logic              cfg_fire;
    logic              out_free;
    logic              zero_cfg;
    logic              tick_idle;
    logic [WIDE_W-1:0] quo_ceil;
    logic [WIDE_W-1:0] x_clamp;
    logic [DATA_W:0]   ta_ceil;
    logic [WIDE_W-1:0] n_wide;
    logic [STEP_BITS-1:0] n_sat;
    logic [TAU_W-1:0]  rnd;
    logic [EXP_W-1:0]  exp_inc;
    logic [ACC_W-1:0]  s30;
    logic [TAU_W-1:0]  s30_clamp;
    logic [TAU_W-1:0]  pos_sum;
    logic [POS_W-1:0]  pos_val;
    logic [DATA_W-1:0] vel_val;

    spt_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    spt_divsqrt u_divsqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (div_cmd),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_quo),
        .rem_nz (div_rnz)
    );

    // Handshakes
    assign tick_fire  = tick.valid && tick.ready;
    assign cfg_fire   = cfg.valid && cfg.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign tick.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid             = out_valid_reg;
    assign result.sample_time       = out_time_reg;
    assign result.position_fraction = out_pos_reg;
    assign result.velocity          = out_vel_reg;
    assign result.sample_number     = out_num_reg;
    assign result.status            = out_status_reg;

    // Arithmetic around the shared units
    always_comb
    begin
        zero_cfg  = (path_len_reg == '0) || (vel_lim_reg == '0) ||
                    (acc_lim_reg == '0) || (tstep_reg == '0);
        tick_idle = !running_reg || (nsteps_reg == '0);
        quo_ceil  = div_quo + WIDE_W'(div_rnz);
        x_clamp   = (quo_ceil > XMAX) ? XMAX : quo_ceil;
        ta_ceil   = {1'b0, div_quo[DATA_W-1:0]} + (DATA_W+1)'(div_rnz);
        n_wide    = (nv_reg > quo_ceil) ? nv_reg : quo_ceil;
        n_sat     = (n_wide > STEP_MAX) ? STEP_MAX[STEP_BITS-1:0] : n_wide[STEP_BITS-1:0];
        rnd       = q30_round(prod);
        exp_inc   = exp_reg + EXP_W'(1);
        s30       = (plus_reg > minus_reg) ? (plus_reg - minus_reg) : '0;
        s30_clamp = (s30 > ACC_W'(ONE30)) ? ONE30 : s30[TAU_W-1:0];
        pos_sum   = s30_clamp + TAU_W'(POS_ROUND);
        pos_val   = pos_sum[POS_SHIFT+POS_W-1:POS_SHIFT];
        vel_val   = sat32(div_quo >> VEL_SHIFT);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (tick_fire)
                begin
                    if (tick.restart)
                        state_next = S_CHECK;
                    else if (bad_reg || tick_idle)
                        state_next = S_OUT;
                    else
                        state_next = S_S0;
                end
            end
            S_CHECK:    state_next = zero_cfg ? S_OUT : S_NV_DEN;
            S_NV_DEN:   state_next = S_NV_START;
            S_NV_START: state_next = S_NV_WAIT;
            S_NV_WAIT:  state_next = div_done ? S_X_START : S_NV_WAIT;
            S_X_START:  state_next = S_X_WAIT;
            S_X_WAIT:   state_next = div_done ? S_TA_WAIT : S_X_WAIT;
            S_TA_WAIT:  state_next = div_done ? S_NA_WAIT : S_TA_WAIT;
            S_NA_WAIT:
            begin
                if (div_done)
                    state_next = (n_sat == '0) ? S_OUT : S_S0;
            end
            S_S0:       state_next = S_S1;
            S_S1:       state_next = S_S2;
            S_S2:       state_next = S_S3;
            S_S3:       state_next = div_done ? S_P_MUL : S_S3;
            S_P_MUL:    state_next = S_P_CAP;
            S_P_CAP:    state_next = (exp_inc >= EXP_FIRST_TERM) ? S_P_CMUL : S_P_MUL;
            S_P_CMUL:   state_next = S_P_ACC;
            S_P_ACC:    state_next = (exp_reg == EXP_LAST) ? S_U_MUL1 : S_P_MUL;
            S_U_MUL1:   state_next = S_U_CAP1;
            S_U_CAP1:   state_next = S_U_MUL2;
            S_U_MUL2:   state_next = S_U_CAP2;
            S_U_CAP2:   state_next = S_U_MUL3;
            S_U_MUL3:   state_next = S_U_CAP3;
            S_U_CAP3:   state_next = S_U_MUL4;
            S_U_MUL4:   state_next = S_V_START;
            S_V_START:  state_next = S_V_WAIT;
            S_V_WAIT:   state_next = div_done ? S_OUT : S_V_WAIT;
            S_OUT:      state_next = out_free ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    // Operands for the shared multiplier and divider
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        div_cmd = '0;
        div_num = '0;
        div_den = '0;
        case (state_reg)
            S_CHECK:
            begin
                mul_a = vpk_reg;
                mul_b = path_len_reg;
            end
            S_NV_DEN:
            begin
                mul_a = vel_lim_reg;
                mul_b = tstep_reg;
            end
            S_NV_START:
            begin
                div_cmd.start = 1'b1;
                div_num       = work_num_reg;
                div_den       = prod;
            end
            S_NV_WAIT:
            begin
                mul_a = apk_reg;
                mul_b = path_len_reg;
            end
            S_X_START:
            begin
                div_cmd.start = 1'b1;
                div_num       = prod;
                div_den       = WIDE_W'(acc_lim_reg);
            end
            S_X_WAIT:
            begin
                div_cmd.start     = div_done;
                div_cmd.sqrt_mode = 1'b1;
                div_num           = x_clamp << FRAC_BITS;
            end
            S_TA_WAIT:
            begin
                div_cmd.start = div_done;
                div_num       = WIDE_W'(ta_ceil);
                div_den       = WIDE_W'(tstep_reg);
            end
            S_S0:
            begin
                div_cmd.start = 1'b1;
                div_num       = WIDE_W'(k_reg) << Q30_SHIFT;
                div_den       = WIDE_W'(nsteps_reg);
                mul_a         = DATA_W'(k_reg);
                mul_b         = tstep_reg;
            end
            S_S1:
            begin
                mul_a = DATA_W'(nsteps_reg);
                mul_b = tstep_reg;
            end
            S_P_MUL:
            begin
                mul_a = DATA_W'(p_reg);
                mul_b = DATA_W'(tau_reg);
            end
            S_P_CMUL:
            begin
                mul_a = DATA_W'(poly_coef(exp_reg));
                mul_b = DATA_W'(p_reg);
            end
            S_U_MUL1:
            begin
                mul_a = DATA_W'(u_reg);
                mul_b = DATA_W'(u_reg);
            end
            S_U_MUL2:
            begin
                mul_a = DATA_W'(w_reg);
                mul_b = DATA_W'(u_reg);
            end
            S_U_MUL3:
            begin
                mul_a = DATA_W'(p3_reg);
                mul_b = DATA_W'(w_reg);
            end
            S_U_MUL4:
            begin
                mul_a = DERIV_GAIN;
                mul_b = DATA_W'(w_reg);
            end
            S_V_START:
            begin
                div_cmd.start = 1'b1;
                div_num       = prod << FRAC_BITS;
                div_den       = den_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Configuration and profile state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_len_reg  <= '0;
            vel_lim_reg   <= '0;
            acc_lim_reg   <= '0;
            tstep_reg     <= '0;
            vpk_reg       <= VEL_PEAK_RESET;
            apk_reg       <= ACC_PEAK_RESET;
            state_reg     <= S_IDLE;
            counter_reg   <= '0;
            nsteps_reg    <= '0;
            end_time_reg  <= '0;
            running_reg   <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_fire)
            begin
                case (cfg.index)
                    REG_PATH_LENGTH: path_len_reg <= cfg.data;
                    REG_VEL_LIMIT:   vel_lim_reg  <= cfg.data;
                    REG_ACC_LIMIT:   acc_lim_reg  <= cfg.data;
                    REG_TIME_STEP:   tstep_reg    <= cfg.data;
                    REG_VEL_PEAK:    vpk_reg      <= cfg.data;
                    REG_ACC_PEAK:    apk_reg      <= cfg.data;
                    default:         path_len_reg <= path_len_reg;
                endcase
            end

            // Output register: load a finished sample, drop it once taken
            if ((state_reg == S_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (tick_fire && !tick.restart && !bad_reg)
                    begin
                        if (tick_idle || (counter_reg >= nsteps_reg))
                            running_reg <= 1'b0;
                        else
                            counter_reg <= counter_reg + STEP_BITS'(1);
                    end
                end
                S_CHECK:
                begin
                    if (zero_cfg)
                    begin
                        bad_reg      <= 1'b1;
                        running_reg  <= 1'b0;
                        nsteps_reg   <= '0;
                        end_time_reg <= '0;
                        counter_reg  <= '0;
                    end
                end
                S_NA_WAIT:
                begin
                    if (div_done)
                    begin
                        if (n_sat == '0)
                        begin
                            bad_reg      <= 1'b1;
                            running_reg  <= 1'b0;
                            nsteps_reg   <= '0;
                            end_time_reg <= '0;
                            counter_reg  <= '0;
                        end
                        else
                        begin
                            bad_reg     <= 1'b0;
                            running_reg <= 1'b1;
                            nsteps_reg  <= n_sat;
                            counter_reg <= STEP_BITS'(1);
                        end
                    end
                end
                S_S2:
                begin
                    if (restart_reg)
                        end_time_reg <= sat32(prod);
                end
                default:
                begin
                    bad_reg <= bad_reg;
                end
            endcase
        end
    end

    // Working and staging registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (tick_fire)
                begin
                    restart_reg <= tick.restart;
                    if (!tick.restart)
                    begin
                        if (bad_reg)
                        begin
                            time_reg <= '0;
                            pos_reg  <= '0;
                            vel_reg  <= '0;
                            k_reg    <= '0;
                            st_reg   <= ST_ERR;
                        end
                        else if (tick_idle)
                        begin
                            time_reg <= end_time_reg;
                            pos_reg  <= (nsteps_reg != '0) ? POS_ONE : '0;
                            vel_reg  <= '0;
                            k_reg    <= nsteps_reg;
                            st_reg   <= ST_IDLE;
                        end
                        else if (counter_reg >= nsteps_reg)
                        begin
                            k_reg  <= nsteps_reg;
                            st_reg <= ST_LAST;
                        end
                        else
                        begin
                            k_reg  <= counter_reg;
                            st_reg <= ST_RUN;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if (zero_cfg)
                begin
                    time_reg <= '0;
                    pos_reg  <= '0;
                    vel_reg  <= '0;
                    k_reg    <= '0;
                    st_reg   <= ST_ERR;
                end
            end
            S_NV_DEN:
            begin
                work_num_reg <= prod;
            end
            S_NV_WAIT:
            begin
                if (div_done)
                    nv_reg <= quo_ceil;
            end
            S_NA_WAIT:
            begin
                if (div_done)
                begin
                    time_reg <= '0;
                    pos_reg  <= '0;
                    vel_reg  <= '0;
                    k_reg    <= '0;
                    st_reg   <= (n_sat == '0) ? ST_ERR : ST_RUN;
                end
            end
            S_S1:
            begin
                time_reg <= sat32(prod);
            end
            S_S2:
            begin
                den_reg <= prod;
            end
            S_S3:
            begin
                if (div_done)
                begin
                    tau_reg   <= div_quo[TAU_W-1:0];
                    u_reg     <= ONE30 - div_quo[TAU_W-1:0];
                    p_reg     <= div_quo[TAU_W-1:0];
                    exp_reg   <= EXP_W'(1);
                    plus_reg  <= '0;
                    minus_reg <= '0;
                end
            end
            S_P_CAP:
            begin
                p_reg   <= rnd;
                exp_reg <= exp_inc;
                if (exp_inc == EXP_P3)
                    p3_reg <= rnd;
            end
            S_P_ACC:
            begin
                // odd powers carry the negative coefficients
                if (exp_reg[0])
                    minus_reg <= minus_reg + prod[ACC_W-1:0];
                else
                    plus_reg <= plus_reg + prod[ACC_W-1:0];
            end
            S_U_CAP1, S_U_CAP2, S_U_CAP3:
            begin
                w_reg <= rnd;
            end
            S_V_WAIT:
            begin
                if (div_done)
                begin
                    vel_reg <= vel_val;
                    pos_reg <= pos_val;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_time_reg   <= time_reg;
                    out_pos_reg    <= pos_reg;
                    out_vel_reg    <= vel_reg;
                    out_num_reg    <= k_reg;
                    out_status_reg <= st_reg;
                end
            end
            default:
            begin
                w_reg <= w_reg;
            end
        endcase
    end

    `SPT_ASSERT_NEVER(a_run_and_bad, running_reg && bad_reg, "running with bad parameters")
    `SPT_ASSERT(a_counter_bound, running_reg |-> counter_reg <= nsteps_reg, "counter past end")
    `SPT_ASSERT(a_err_zero, out_valid_reg && out_status_reg == ST_ERR |-> out_num_reg == '0 && out_vel_reg == '0, "error sample not zero")

endmodule

`default_nettype wire

// File: rtl/core/spt_mul.sv
// Shared 32x32 multiplier with registered product.
`default_nettype none

module spt_mul import spt_pkg::*; (
    input  logic              clk,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [WIDE_W-1:0] prod
);

    logic [WIDE_W-1:0] prod_reg;

    // One product per cycle, read in the cycle after the operands are applied
    always_ff @(posedge clk)
    begin
        prod_reg <= {{(WIDE_W-DATA_W){1'b0}}, a} * {{(WIDE_W-DATA_W){1'b0}}, b};
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: rtl/core/spt_divsqrt.sv
// Shared bit-serial divider and square root unit, one result bit per cycle.
`default_nettype none
`include "septic_polynomial_trajectory_gen_core_assert.svh"

module spt_divsqrt import spt_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  div_cmd_t          cmd,
    input  logic [WIDE_W-1:0] num,
    input  logic [WIDE_W-1:0] den,
    output logic              done,
    output logic [WIDE_W-1:0] quo,
    output logic              rem_nz
);

    localparam int TRIAL_W = WIDE_W + 2;
    localparam int SQ_REM_W = SQRT_ITERS + 2;

    logic                  busy_reg;
    logic                  done_reg;
    logic [ITER_CNT_W-1:0] cnt_reg;
    logic                  sqrt_reg;
    logic [WIDE_W-1:0]     num_reg;
    logic [WIDE_W-1:0]     den_reg;
    logic [WIDE_W-1:0]     rem_reg;
    logic [WIDE_W-1:0]     quo_reg;

    logic [TRIAL_W-1:0]    trial_a;
    logic [TRIAL_W-1:0]    trial_b;
    logic [TRIAL_W-1:0]    diff;
    logic                  fits;
    logic [ITER_CNT_W-1:0] last_cnt;

    // Trial subtract: divide shifts in one bit, root shifts in two
    always_comb
    begin
        if (sqrt_reg)
        begin
            trial_a = {{(TRIAL_W-SQ_REM_W-2){1'b0}}, rem_reg[SQ_REM_W-1:0],
                       num_reg[WIDE_W-1:WIDE_W-2]};
            trial_b = {{(TRIAL_W-SQRT_ITERS-2){1'b0}}, quo_reg[SQRT_ITERS-1:0], 2'b01};
            last_cnt = ITER_CNT_W'(SQRT_ITERS - 1);
        end
        else
        begin
            trial_a = {1'b0, rem_reg, num_reg[WIDE_W-1]};
            trial_b = {2'b00, den_reg};
            last_cnt = ITER_CNT_W'(DIV_ITERS - 1);
        end
        fits = (trial_a >= trial_b);
        diff = trial_a - trial_b;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + ITER_CNT_W'(1);
                if (cnt_reg == last_cnt)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sqrt_reg <= cmd.sqrt_mode;
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[WIDE_W-1:0] : trial_a[WIDE_W-1:0];
            quo_reg <= {quo_reg[WIDE_W-2:0], fits};
            num_reg <= sqrt_reg ? (num_reg << 2) : (num_reg << 1);
        end
    end

    assign done   = done_reg;
    assign quo    = quo_reg;
    assign rem_nz = (rem_reg != '0);

    `SPT_ASSERT(a_no_start_busy, cmd.start |-> !busy_reg, "start while unit busy")
    `SPT_ASSERT(a_done_after_busy, done_reg |-> $past(busy_reg), "done without run")
    `SPT_ASSERT_NEVER(a_done_and_busy, done_reg && busy_reg, "done while busy")

endmodule

`default_nettype wire
